>>> hw/rtl/event_rate_meter_three_window_defines.svh
// ----------------------------------------------------------------------------
// Event rate meter assertion macros
// Shared property forms for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_RATE_METER_THREE_WINDOW_DEFINES_SVH
`define EVENT_RATE_METER_THREE_WINDOW_DEFINES_SVH

// consequent in the cycle after the antecedent
`define ERM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the same cycle as the antecedent
`define ERM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ermtw_pkg.sv
// ----------------------------------------------------------------------------
// Event rate meter package
// Widths, reset values and register indexes shared by the meter and checker.
// ----------------------------------------------------------------------------
package ermtw_pkg;

  localparam int unsigned RATE_FRAC_BITS = 8;
  localparam int unsigned RATE_W         = 32;

  localparam int unsigned TICK_RATE_W = 20;
  localparam int unsigned WIN_W       = 24;
  localparam int unsigned TOT_TICKS_W = 40;
  localparam int unsigned TOT_EVENTS_W = 48;
  localparam int unsigned WIN_SUM_W   = 40;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WIN   = 2'd2;

  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST = 20'd1000;
  localparam logic [WIN_W-1:0]       SHORT_WIN_RST = 24'd1000;
  localparam logic [WIN_W-1:0]       LONG_WIN_RST  = 24'd5000;

  // result word: overall, short, long, short_closed, long_closed
  localparam int unsigned OUT_USED_W  = 3 * RATE_W + 2;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // scaled product and long division
  localparam int unsigned MUL_A_W  = 24;
  localparam int unsigned PROD_W   = TOT_EVENTS_W + TICK_RATE_W;
  localparam int unsigned SHP_W    = PROD_W + RATE_FRAC_BITS;
  localparam int unsigned PHI_W    = SHP_W - RATE_W;
  localparam int unsigned DIV_W    = TOT_TICKS_W;
  localparam int unsigned CMP_W    = (PHI_W > DIV_W + 1) ? PHI_W : DIV_W + 1;
  localparam int unsigned DIV_STEPS = RATE_W;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

endpackage

>>> hw/rtl/event_rate_meter_three_window.sv
// ----------------------------------------------------------------------------
// Three-window event rate meter
// Per base tick: running average rate and short/long window rates, Q24.8
// events per second, via one shared multiplier and one shared subtractor.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  s_axis    | in        | tvalid/tready        | tdata[EVENT_BITS-1:0] event_count
//  m_axis    | out       | tvalid/tready        | tdata: rates and closed flags
//  cfg       | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// Each word computes the overall rate plus one rate per window that closes:
// each rate is a low and a high multiply step, one range check, 32 divide
// steps on the shared subtractor and one store; a saturating rate skips its
// divide steps. Input is not ready while a word is in work.
// A finished result waits in the output register; the next word is taken
// meanwhile and its result holds until the register is free.
// Reset loads the default configuration and clears all accumulators.
// ----------------------------------------------------------------------------
module event_rate_meter_three_window #(
  parameter int unsigned EVENT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // event_count in [EVENT_BITS-1:0], zero pad above
  input  logic [((EVENT_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // overall_rate, short_rate, long_rate, short_closed, long_closed, zero pad
  output logic [ermtw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [ermtw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ermtw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ermtw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACCUM, ST_MUL_LO, ST_MUL_HI, ST_CHECK, ST_DIV, ST_STORE, ST_DONE
  } state_e;

  typedef enum logic [1:0] {JOB_SHORT, JOB_LONG, JOB_OVERALL} job_e;

  state_e state_q;
  job_e   job_q;

  logic [TICK_RATE_W-1:0]  tick_rate_q;
  logic [WIN_W-1:0]        short_win_q;
  logic [WIN_W-1:0]        long_win_q;

  logic [EVENT_BITS-1:0]   ev_q;
  logic [TOT_TICKS_W-1:0]  total_ticks_q;
  logic [TOT_EVENTS_W-1:0] total_events_q;
  logic [WIN_W-1:0]        short_cnt_q;
  logic [WIN_SUM_W-1:0]    short_sum_q;
  logic [WIN_SUM_W-1:0]    short_snap_q;
  logic [WIN_W-1:0]        long_cnt_q;
  logic [WIN_SUM_W-1:0]    long_sum_q;
  logic [WIN_SUM_W-1:0]    long_snap_q;
  logic                    s_closed_q;
  logic                    l_closed_q;

  logic [RATE_W-1:0]       held_short_q;
  logic [RATE_W-1:0]       held_long_q;
  logic [RATE_W-1:0]       overall_q;

  logic [PROD_W-1:0]       prod_q;
  logic [DIV_W-1:0]        rem_q;
  logic [RATE_W-1:0]       quo_q;
  logic [STEP_W-1:0]       step_q;

  logic                    m_valid_q;
  logic [OUT_TDATA_W-1:0]  m_data_q;

  // ---- input capture
  logic [EVENT_BITS-1:0] ev_raw;
  assign ev_raw = s_axis_tdata[EVENT_BITS-1:0];

  // ---- accumulator update
  logic                    tot_full;
  logic [TOT_EVENTS_W:0]   tot_ev_sum;
  logic [TOT_EVENTS_W-1:0] tot_ev_next;
  logic [WIN_W-1:0]        short_cnt_inc;
  logic [WIN_SUM_W:0]      short_sum_raw;
  logic [WIN_SUM_W-1:0]    short_sum_inc;
  logic                    short_close;
  logic [WIN_W-1:0]        long_cnt_inc;
  logic [WIN_SUM_W:0]      long_sum_raw;
  logic [WIN_SUM_W-1:0]    long_sum_inc;
  logic                    long_close;

  always_comb begin
    tot_full      = &total_ticks_q;
    tot_ev_sum    = {1'b0, total_events_q} + (TOT_EVENTS_W+1)'(ev_q);
    tot_ev_next   = tot_ev_sum[TOT_EVENTS_W] ? '1 : tot_ev_sum[TOT_EVENTS_W-1:0];
    short_cnt_inc = short_cnt_q + WIN_W'(1);
    short_sum_raw = {1'b0, short_sum_q} + (WIN_SUM_W+1)'(ev_q);
    short_sum_inc = short_sum_raw[WIN_SUM_W] ? '1 : short_sum_raw[WIN_SUM_W-1:0];
    short_close   = short_cnt_inc >= short_win_q;
    long_cnt_inc  = long_cnt_q + WIN_W'(1);
    long_sum_raw  = {1'b0, long_sum_q} + (WIN_SUM_W+1)'(ev_q);
    long_sum_inc  = long_sum_raw[WIN_SUM_W] ? '1 : long_sum_raw[WIN_SUM_W-1:0];
    long_close    = long_cnt_inc >= long_win_q;
  end

  // ---- shared multiplier and subtractor
  logic [TOT_EVENTS_W-1:0]       op_a;
  logic [DIV_W-1:0]              op_d;
  logic [MUL_A_W-1:0]            mul_a;
  logic [MUL_A_W+TICK_RATE_W-1:0] mul_p;
  logic [SHP_W-1:0]              shp;
  logic [CMP_W-1:0]              cmp_a;
  logic [CMP_W-1:0]              cmp_b;
  logic [CMP_W-1:0]              cmp_diff;
  logic                          cmp_ge;

  always_comb begin
    case (job_q)
      JOB_SHORT: begin
        op_a = TOT_EVENTS_W'(short_snap_q);
        op_d = DIV_W'(short_win_q);
      end
      JOB_LONG: begin
        op_a = TOT_EVENTS_W'(long_snap_q);
        op_d = DIV_W'(long_win_q);
      end
      default: begin
        op_a = total_events_q;
        op_d = total_ticks_q;
      end
    endcase
    mul_a = (state_q == ST_MUL_HI) ? op_a[TOT_EVENTS_W-1:MUL_A_W] : op_a[MUL_A_W-1:0];
    mul_p = (MUL_A_W+TICK_RATE_W)'(mul_a) * (MUL_A_W+TICK_RATE_W)'(tick_rate_q);
    shp   = SHP_W'(prod_q) << RATE_FRAC_BITS;
    if (state_q == ST_CHECK) begin
      cmp_a = CMP_W'(shp[SHP_W-1:RATE_W]);
    end else begin
      cmp_a = CMP_W'({rem_q, quo_q[RATE_W-1]});
    end
    cmp_b    = CMP_W'(op_d);
    cmp_ge   = cmp_a >= cmp_b;
    cmp_diff = cmp_a - cmp_b;
  end

  // ---- configuration decode
  logic cfg_hit;
  always_comb begin
    case (cfg_idx_i)
      REG_TICK_RATE: cfg_hit = cfg_we_i && (cfg_data_i[TICK_RATE_W-1:0] != '0);
      REG_SHORT_WIN: cfg_hit = cfg_we_i && (cfg_data_i[WIN_W-1:0] != '0);
      REG_LONG_WIN:  cfg_hit = cfg_we_i && (cfg_data_i[WIN_W-1:0] != '0);
      default:       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      job_q          <= JOB_OVERALL;
      tick_rate_q    <= TICK_RATE_RST;
      short_win_q    <= SHORT_WIN_RST;
      long_win_q     <= LONG_WIN_RST;
      ev_q           <= '0;
      total_ticks_q  <= '0;
      total_events_q <= '0;
      short_cnt_q    <= '0;
      short_sum_q    <= '0;
      short_snap_q   <= '0;
      long_cnt_q     <= '0;
      long_sum_q     <= '0;
      long_snap_q    <= '0;
      s_closed_q     <= 1'b0;
      l_closed_q     <= 1'b0;
      held_short_q   <= '0;
      held_long_q    <= '0;
      overall_q      <= '0;
      prod_q         <= '0;
      rem_q          <= '0;
      quo_q          <= '0;
      step_q         <= '0;
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
    end else begin
      if (cfg_hit) begin
        case (cfg_idx_i)
          REG_TICK_RATE: tick_rate_q <= cfg_data_i[TICK_RATE_W-1:0];
          REG_SHORT_WIN: short_win_q <= cfg_data_i[WIN_W-1:0];
          default:       long_win_q  <= cfg_data_i[WIN_W-1:0];
        endcase
        total_ticks_q  <= '0;
        total_events_q <= '0;
        short_cnt_q    <= '0;
        short_sum_q    <= '0;
        long_cnt_q     <= '0;
        long_sum_q     <= '0;
      end

      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            // drop negative counts
            ev_q    <= ev_raw[EVENT_BITS-1] ? '0 : ev_raw;
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (!tot_full) begin
            total_ticks_q  <= total_ticks_q + TOT_TICKS_W'(1);
            total_events_q <= tot_ev_next;
          end
          s_closed_q <= short_close;
          l_closed_q <= long_close;
          if (short_close) begin
            short_snap_q <= short_sum_inc;
            short_cnt_q  <= '0;
            short_sum_q  <= '0;
          end else begin
            short_cnt_q  <= short_cnt_inc;
            short_sum_q  <= short_sum_inc;
          end
          if (long_close) begin
            long_snap_q <= long_sum_inc;
            long_cnt_q  <= '0;
            long_sum_q  <= '0;
          end else begin
            long_cnt_q  <= long_cnt_inc;
            long_sum_q  <= long_sum_inc;
          end
          if (short_close) begin
            job_q <= JOB_SHORT;
          end else if (long_close) begin
            job_q <= JOB_LONG;
          end else begin
            job_q <= JOB_OVERALL;
          end
          state_q <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          prod_q  <= PROD_W'(mul_p);
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          prod_q  <= prod_q + (PROD_W'(mul_p) << MUL_A_W);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (cmp_ge) begin
            // saturate
            quo_q   <= '1;
            state_q <= ST_STORE;
          end else begin
            rem_q   <= shp[RATE_W+DIV_W-1:RATE_W];
            quo_q   <= shp[RATE_W-1:0];
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= cmp_ge ? cmp_diff[DIV_W-1:0] : {rem_q[DIV_W-2:0], quo_q[RATE_W-1]};
          quo_q  <= {quo_q[RATE_W-2:0], cmp_ge};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          state_q <= ST_MUL_LO;
          case (job_q)
            JOB_SHORT: begin
              held_short_q <= quo_q;
              job_q        <= l_closed_q ? JOB_LONG : JOB_OVERALL;
            end
            JOB_LONG: begin
              held_long_q <= quo_q;
              job_q       <= JOB_OVERALL;
            end
            default: begin
              overall_q <= quo_q;
              state_q   <= ST_DONE;
            end
          endcase
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {{OUT_PAD_W{1'b0}}, l_closed_q, s_closed_q,
                          held_long_q, held_short_q, overall_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> hw/rtl/ermtw_checker.sv
// ----------------------------------------------------------------------------
// Event rate meter checker
// Port-level properties of the meter, bound to every instance of it.
// ----------------------------------------------------------------------------
`include "event_rate_meter_three_window_defines.svh"

module ermtw_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  // overall_rate, short_rate, long_rate, short_closed, long_closed, zero pad
  input logic [ermtw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import ermtw_pkg::*;

  `ERM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
  `ERM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after a word was taken")
  `ERM_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared one cycle after input")
  `ERM_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0, "result pad bits not zero")

endmodule

bind event_rate_meter_three_window ermtw_checker u_ermtw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Three-window event rate meter testbench
// Streams event counts through the meter under random source gaps and sink
// stalls. A scoreboard predicts the overall, short and long window rates and
// the window-closed flags for every accepted word and compares them field by
// field. Configuration changes happen between phases, while the meter is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ermtw_pkg::*;

  localparam int unsigned EV_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic              long_closed;
    logic              short_closed;
    logic [RATE_W-1:0] long_rate;
    logic [RATE_W-1:0] short_rate;
    logic [RATE_W-1:0] overall_rate;
  } meter_result_t;

  class rate_scoreboard;
    logic [TICK_RATE_W-1:0]  tick_rate;
    logic [WIN_W-1:0]        short_win;
    logic [WIN_W-1:0]        long_win;
    logic [TOT_TICKS_W-1:0]  total_ticks;
    logic [TOT_EVENTS_W-1:0] total_events;
    logic [WIN_W-1:0]        short_cnt;
    logic [WIN_W-1:0]        long_cnt;
    logic [WIN_SUM_W-1:0]    short_sum;
    logic [WIN_SUM_W-1:0]    long_sum;
    logic [RATE_W-1:0]       held_short;
    logic [RATE_W-1:0]       held_long;
    meter_result_t           expected_words[$];
    int unsigned             errors;

    function new();
      tick_rate  = TICK_RATE_RST;
      short_win  = SHORT_WIN_RST;
      long_win   = LONG_WIN_RST;
      held_short = '0;
      held_long  = '0;
      errors     = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      total_ticks  = '0;
      total_events = '0;
      short_cnt    = '0;
      long_cnt     = '0;
      short_sum    = '0;
      long_sum     = '0;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function logic [63:0] sat_add(logic [63:0] acc, logic [63:0] v, logic [63:0] maxv);
      return (v > maxv - acc) ? maxv : acc + v;
    endfunction

    function logic [RATE_W-1:0] scaled(logic [TOT_EVENTS_W-1:0] a,
                                       logic [TICK_RATE_W-1:0] b,
                                       logic [TOT_TICKS_W-1:0] d);
      logic [127:0] wa, wb, wd, q;
      wa = a;
      wb = b;
      wd = d;
      if (wd == 0) return '1;
      q = ((wa * wb) << RATE_FRAC_BITS) / wd;
      if (q[127:RATE_W] != 0) return '1;
      return q[RATE_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TICK_RATE: begin
          if (data[TICK_RATE_W-1:0] == 0) return;
          tick_rate = data[TICK_RATE_W-1:0];
        end
        REG_SHORT_WIN: begin
          if (data[WIN_W-1:0] == 0) return;
          short_win = data[WIN_W-1:0];
        end
        REG_LONG_WIN: begin
          if (data[WIN_W-1:0] == 0) return;
          long_win = data[WIN_W-1:0];
        end
        default: return;
      endcase
      clear_sums();
    endfunction

    function void note_tick(logic [EV_W-1:0] raw);
      logic [63:0]   ev;
      logic [63:0]   tmp;
      meter_result_t r;
      ev = raw[EV_W-1] ? 64'd0 : 64'(raw);
      r.short_closed = 1'b0;
      r.long_closed  = 1'b0;
      if (total_ticks != '1) begin
        total_ticks = total_ticks + 1'b1;
        tmp = sat_add(64'(total_events), ev, {16'd0, {TOT_EVENTS_W{1'b1}}});
        total_events = tmp[TOT_EVENTS_W-1:0];
      end
      short_cnt = short_cnt + 1'b1;
      tmp = sat_add(64'(short_sum), ev, {24'd0, {WIN_SUM_W{1'b1}}});
      short_sum = tmp[WIN_SUM_W-1:0];
      if (short_cnt >= short_win) begin
        held_short = scaled(48'(short_sum), tick_rate, 40'(short_win));
        short_cnt = '0;
        short_sum = '0;
        r.short_closed = 1'b1;
      end
      long_cnt = long_cnt + 1'b1;
      tmp = sat_add(64'(long_sum), ev, {24'd0, {WIN_SUM_W{1'b1}}});
      long_sum = tmp[WIN_SUM_W-1:0];
      if (long_cnt >= long_win) begin
        held_long = scaled(48'(long_sum), tick_rate, 40'(long_win));
        long_cnt = '0;
        long_sum = '0;
        r.long_closed = 1'b1;
      end
      r.overall_rate = scaled(total_events, tick_rate, total_ticks);
      r.short_rate   = held_short;
      r.long_rate    = held_long;
      expected_words.push_back(r);
    endfunction

    function void report(string field, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: %s expected %h got %h", field, want, got);
      end
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] data);
      meter_result_t got, want;
      got = data[OUT_USED_W-1:0];
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: result word with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      report("overall_rate", want.overall_rate, got.overall_rate);
      report("short_rate", want.short_rate, got.short_rate);
      report("long_rate", want.long_rate, got.long_rate);
      report("short_closed", 32'(want.short_closed), 32'(got.short_closed));
      report("long_closed", 32'(want.long_closed), 32'(got.long_closed));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // event_count
  logic [EV_W-1:0]        s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // overall_rate, short_rate, long_rate, short_closed, long_closed, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  rate_scoreboard sb;
  bit             rx_steady;

  event_rate_meter_three_window #(
    .EVENT_BITS(EV_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 250);
  endfunction

  function automatic logic [EV_W-1:0] pick_event();
    int unsigned     r;
    logic [EV_W-1:0] v;
    r = $urandom_range(0, 99);
    v = EV_W'($urandom);
    if (r < 35) return EV_W'($urandom_range(0, 20));
    if (r < 55) return v;
    if (r < 65) return 16'h7FFF;
    if (r < 75) return v | 16'h8000;
    if (r < 80) return '0;
    return EV_W'($urandom_range(0, 2000));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_tick_rate();
    case ($urandom_range(0, 5))
      0:       return 24'd1;
      1:       return 24'h0FFFFF;
      2:       return 24'd1000000;
      3:       return 24'($urandom_range(1, 2000));
      4:       return 24'($urandom);
      default: return 24'd0;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_window(int unsigned span);
    case ($urandom_range(0, 5))
      0:       return 24'd1;
      1:       return 24'($urandom_range(1, 8));
      2:       return 24'($urandom_range(1, span));
      3:       return 24'hFFFFFF;
      4:       return 24'd0;
      default: return 24'($urandom_range(2, span));
    endcase
  endfunction

  task automatic send_tick(input logic [EV_W-1:0] ev, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ev;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(ev);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sink: random stalls, checked at each accepted word
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady) hold = pick_gap();
      end
    end
  end

  initial begin
    #12_800_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [EV_W-1:0] directed[$];
    bit              tx_steady;
    int unsigned     n;
    sb            = new();
    rx_steady     = 1'b0;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: field extremes and negative counts
    directed = '{16'd0, 16'd1, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFE, 16'h5555, 16'hAAAA};
    foreach (directed[i]) send_tick(directed[i], 1'b0);
    end_burst();

    // fastest tick rate, one- and two-tick windows: saturating rates
    write_reg(REG_TICK_RATE, 24'hFFFFFF);
    write_reg(REG_SHORT_WIN, 24'd1);
    write_reg(REG_LONG_WIN, 24'd2);
    directed = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'h8000, 16'd1};
    foreach (directed[i]) send_tick(directed[i], 1'b0);
    end_burst();

    // slowest tick rate, long window that never closes
    write_reg(REG_TICK_RATE, 24'd1);
    write_reg(REG_SHORT_WIN, 24'd3);
    write_reg(REG_LONG_WIN, 24'hFFFFFF);
    directed = '{16'd0, 16'd1, 16'd2, 16'h7FFF};
    foreach (directed[i]) send_tick(directed[i], 1'b1);
    end_burst();

    // zero writes and the spare index leave the sums running
    write_reg(REG_TICK_RATE, 24'd0);
    write_reg(REG_SHORT_WIN, 24'd0);
    write_reg(REG_LONG_WIN, 24'd0);
    write_reg(REG_SPARE, 24'($urandom));
    directed = '{16'd5, 16'd7, 16'h9000, 16'd3};
    foreach (directed[i]) send_tick(directed[i], 1'b0);
    end_burst();

    for (int p = 0; p < 9; p++) begin
      if ($urandom_range(0, 99) < 60) write_reg(REG_TICK_RATE, pick_tick_rate());
      if ($urandom_range(0, 99) < 60) write_reg(REG_SHORT_WIN, pick_window(30));
      if ($urandom_range(0, 99) < 60) write_reg(REG_LONG_WIN, pick_window(60));
      if ($urandom_range(0, 99) < 15) write_reg(REG_SPARE, 24'($urandom));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 60);
      for (int k = 0; k < n; k++) send_tick(pick_event(), tx_steady);
      end_burst();
    end

    rx_steady = 1'b0;
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
